// ===== hw/rtl/gpalu_pkg.sv =====
// Package for the GF(2) polynomial ALU.
// Holds the transaction payload types, operation codes and the control/status
// structs shared by the top level and the engine. No dependencies.
`timescale 1ns / 1ps

package gpalu_pkg;

  localparam int unsigned OPND_W = 32;
  localparam int unsigned MAIN_W = 63;

  typedef logic [1:0]        op_code_t;
  typedef logic [OPND_W-1:0] opnd_t;
  typedef logic [MAIN_W-1:0] main_t;

  localparam op_code_t OP_MUL = 2'd0;
  localparam op_code_t OP_DIV = 2'd1;
  localparam op_code_t OP_GCD = 2'd2;

  typedef struct packed {
    op_code_t req_type;
    opnd_t    operand_a;
    opnd_t    operand_b;
  } req_t;

  typedef struct packed {
    main_t main_value;
    opnd_t remainder_value;
    logic  error_flag;
  } rsp_t;

  typedef struct packed {
    logic start;
    logic take;
  } eng_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } eng_sts_t;

endpackage

// ===== hw/rtl/gpalu_engine.sv =====
// Sequencer plus shared shift/xor datapath for multiply, divide and gcd.
// One step per cycle; result held until the top level takes it.
// Depends on gpalu_pkg.
`timescale 1ns / 1ps

module gpalu_engine #(
  parameter int unsigned POLY_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gpalu_pkg::eng_ctl_t ctl_i,
  input  gpalu_pkg::req_t   req_i,
  output gpalu_pkg::eng_sts_t sts_o,
  output gpalu_pkg::rsp_t   rsp_o
);

  localparam int unsigned PRODW = 2 * POLY_BITS - 1;
  localparam int unsigned KW    = $clog2(POLY_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_NORM,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e                 state_q;
  gpalu_pkg::op_code_t    op_q;
  logic [POLY_BITS-1:0]   x_q;
  logic [POLY_BITS-1:0]   dv_q;
  logic [POLY_BITS-1:0]   dsh_q;
  logic [POLY_BITS-1:0]   msk_q;
  logic [POLY_BITS-1:0]   quo_q;
  logic [KW-1:0]          k_q;
  logic [PRODW-1:0]       acc_q;
  logic [PRODW-1:0]       mpa_q;
  gpalu_pkg::rsp_t        rsp_q;

  logic [POLY_BITS-1:0]   a_in, b_in;
  logic                   hit;
  logic [POLY_BITS-1:0]   x_nxt;
  logic [POLY_BITS-1:0]   quo_nxt;

  assign a_in    = req_i.operand_a[POLY_BITS-1:0];
  assign b_in    = req_i.operand_b[POLY_BITS-1:0];
  assign hit     = |(x_q & msk_q);
  assign x_nxt   = hit ? (x_q ^ dsh_q) : x_q;
  assign quo_nxt = {quo_q[POLY_BITS-2:0], hit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= gpalu_pkg::OP_MUL;
      x_q     <= '0;
      dv_q    <= '0;
      dsh_q   <= '0;
      msk_q   <= '0;
      quo_q   <= '0;
      k_q     <= '0;
      acc_q   <= '0;
      mpa_q   <= '0;
      rsp_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (ctl_i.start) begin
            op_q  <= req_i.req_type;
            x_q   <= a_in;
            dv_q  <= b_in;
            dsh_q <= b_in;
            k_q   <= '0;
            case (req_i.req_type)
              gpalu_pkg::OP_MUL: begin
                acc_q   <= '0;
                mpa_q   <= PRODW'(a_in);
                state_q <= ST_MUL;
              end
              gpalu_pkg::OP_DIV: begin
                if (b_in == '0) begin
                  rsp_q.error_flag <= 1'b1;
                  state_q          <= ST_DONE;
                end else begin
                  state_q <= ST_NORM;
                end
              end
              gpalu_pkg::OP_GCD: begin
                if (a_in == '0 && b_in == '0) begin
                  rsp_q.error_flag <= 1'b1;
                  state_q          <= ST_DONE;
                end else if (b_in == '0) begin
                  rsp_q.main_value <= gpalu_pkg::main_t'(a_in);
                  state_q          <= ST_DONE;
                end else begin
                  state_q <= ST_NORM;
                end
              end
              default: begin
                state_q <= ST_DONE;
              end
            endcase
          end
        end
        ST_MUL: begin
          if (dsh_q == '0) begin
            rsp_q.main_value <= gpalu_pkg::main_t'(acc_q);
            state_q          <= ST_DONE;
          end else begin
            if (dsh_q[0]) begin
              acc_q <= acc_q ^ mpa_q;
            end
            mpa_q <= {mpa_q[PRODW-2:0], 1'b0};
            dsh_q <= {1'b0, dsh_q[POLY_BITS-1:1]};
          end
        end
        ST_NORM: begin
          // align divisor so its leading term sits in the top bit
          if (dsh_q[POLY_BITS-1]) begin
            msk_q   <= {1'b1, {(POLY_BITS-1){1'b0}}};
            quo_q   <= '0;
            state_q <= ST_DIV;
          end else begin
            dsh_q <= {dsh_q[POLY_BITS-2:0], 1'b0};
            k_q   <= k_q + KW'(1);
          end
        end
        ST_DIV: begin
          quo_q <= quo_nxt;
          if (k_q == '0) begin
            if (op_q == gpalu_pkg::OP_GCD) begin
              if (x_nxt == '0) begin
                rsp_q.main_value <= gpalu_pkg::main_t'(dv_q);
                state_q          <= ST_DONE;
              end else begin
                x_q     <= dv_q;
                dv_q    <= x_nxt;
                dsh_q   <= x_nxt;
                state_q <= ST_NORM;
              end
            end else begin
              rsp_q.main_value      <= gpalu_pkg::main_t'(quo_nxt);
              rsp_q.remainder_value <= gpalu_pkg::opnd_t'(x_nxt);
              state_q               <= ST_DONE;
            end
          end else begin
            x_q   <= x_nxt;
            k_q   <= k_q - KW'(1);
            dsh_q <= {1'b0, dsh_q[POLY_BITS-1:1]};
            msk_q <= {1'b0, msk_q[POLY_BITS-1:1]};
          end
        end
        ST_DONE: begin
          if (ctl_i.take) begin
            rsp_q   <= '0;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign sts_o.idle = (state_q == ST_IDLE);
  assign sts_o.done = (state_q == ST_DONE);
  assign rsp_o      = rsp_q;

endmodule

// ===== hw/rtl/gf2_polynomial_alu.sv =====
// GF(2) polynomial ALU: carry-less multiply, divide with remainder, gcd.
// Multiply steps once per multiplier bit up to its leading one; divide aligns the
// divisor, then steps once per quotient bit; gcd repeats the divide sequence once
// per Euclid round.
// One transaction in flight; next one accepted in the cycle after the result is handed to the output register.
// Reset: asynchronous, active low; engine returns to idle and the output is emptied.
`timescale 1ns / 1ps

module gf2_polynomial_alu #(
  parameter int unsigned POLY_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  gpalu_pkg::req_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output gpalu_pkg::rsp_t out_data_o
);

  gpalu_pkg::eng_ctl_t ctl;
  gpalu_pkg::eng_sts_t sts;
  gpalu_pkg::rsp_t     eng_rsp;
  logic                out_valid_q;
  gpalu_pkg::rsp_t     out_data_q;

  assign in_stall_o = ~sts.idle;
  assign ctl.start  = in_valid_i & sts.idle;
  assign ctl.take   = sts.done & (~out_valid_q | ~out_stall_i);

  gpalu_engine #(
    .POLY_BITS(POLY_BITS)
  ) u_engine (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ctl),
    .req_i (in_data_i),
    .sts_o (sts),
    .rsp_o (eng_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else if (ctl.take) begin
      out_valid_q <= 1'b1;
      out_data_q  <= eng_rsp;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
